[rtl/core/tcs_pkg.sv]
// package with result type, token codes and character classes for the token classifier
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

  // token kinds
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_OPEN   = 3'd2;
  localparam logic [2:0] KIND_CLOSE  = 3'd3;
  localparam logic [2:0] KIND_COMMA  = 3'd4;
  localparam logic [2:0] KIND_SEMI   = 3'd5;
  localparam logic [2:0] KIND_OPER   = 3'd6;
  localparam logic [2:0] KIND_END    = 3'd7;

  // keyword codes
  localparam logic [1:0] KW_NONE   = 2'd0;
  localparam logic [1:0] KW_DEF    = 2'd1;
  localparam logic [1:0] KW_EXTERN = 2'd2;

  // special characters
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  // number of result slots in the output queue
  localparam int unsigned RES_DEPTH = 2;

  // one result item
  typedef struct packed {
    logic [7:0] tok_char;
    logic [2:0] kind;
    logic       first;
    logic       last;
    logic [1:0] keyword;
  } tok_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_COMMA) ||
           (c == CH_SEMI) || (c == CH_HASH);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return !is_space(c) && !is_alnum(c) && !is_single(c);
  endfunction

  // letters of "def" by position
  function automatic logic [7:0] kw_def_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h64;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // letters of "extern" by position
  function automatic logic [7:0] kw_extern_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h65;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h74;
      3'd3:    r = 8'h65;
      3'd4:    r = 8'h72;
      3'd5:    r = 8'h6e;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/token_classifier_stream_unit.sv]
// streaming lexer that tags each token character with kind and boundaries
`timescale 1ns / 1ps
`default_nettype none

// Takes one source byte per cycle while in_ready is high (or an end mark)
// and returns the token characters one per result item, each tagged with
// its kind, first/last flags and, on the final identifier character, the
// keyword def or extern. One character is held back until the next byte
// shows where the token ends, so results trail the input by one item; the
// end mark flushes it and adds an end token. An item yields zero, one or
// two results at once; results go through a two-entry output queue. With
// the output side always ready one item is taken every cycle; an item with
// two results waits while the queue is full until an entry drains.
module token_classifier_stream_unit
  import tcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_end_mark,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_tok_char,
  output logic [2:0]      out_kind,
  output logic            out_first,
  output logic            out_last,
  output logic [1:0]      out_keyword
);

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_OPER    = 3'd4
  } mode_t;

  // scanner state
  mode_t      mode_r, mode_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       held_first_r, held_first_nxt;
  logic [2:0] name_len_r, name_len_nxt;
  logic       def_ok_r, def_ok_nxt;
  logic       ext_ok_r, ext_ok_nxt;

  // output queue
  tok_res_t   res_r [RES_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  tok_res_t   res0, res1;
  logic [1:0] n_res;
  logic       in_acc, out_acc;
  logic [1:0] n_push;
  logic [2:0] room_need;

  // step logic: next scanner state and results for the current input item
  always_comb begin
    logic       extend_ok;
    logic       classify;
    logic [2:0] held_kind;
    logic [1:0] kw;
    logic [2:0] p;
    tok_res_t   r_flush;
    tok_res_t   r_single;
    logic       has_flush;
    logic       has_single;
    logic       start_id;

    mode_nxt       = mode_r;
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    name_len_nxt   = name_len_r;
    def_ok_nxt     = def_ok_r;
    ext_ok_nxt     = ext_ok_r;
    extend_ok      = 1'b0;
    classify       = 1'b0;
    has_flush      = 1'b0;
    has_single     = 1'b0;
    start_id       = 1'b0;
    p              = name_len_r;

    // kind of the held character
    case (mode_r)
      MODE_IDENT:  held_kind = KIND_IDENT;
      MODE_NUMBER: held_kind = KIND_NUMBER;
      default:     held_kind = KIND_OPER;
    endcase

    // keyword seen on the last identifier character
    kw = KW_NONE;
    if (mode_r == MODE_IDENT) begin
      if (def_ok_r && name_len_r == 3'd3) begin
        kw = KW_DEF;
      end else if (ext_ok_r && name_len_r == 3'd6) begin
        kw = KW_EXTERN;
      end
    end

    r_flush.tok_char  = held_char_r;
    r_flush.kind      = held_kind;
    r_flush.first     = held_first_r;
    r_flush.last      = 1'b1;
    r_flush.keyword   = kw;

    r_single.tok_char = in_ch;
    r_single.kind     = KIND_OPEN;
    r_single.first    = 1'b1;
    r_single.last     = 1'b1;
    r_single.keyword  = KW_NONE;

    if (in_end_mark) begin
      // flush held character, then end token
      has_flush         = held_valid_r;
      has_single        = 1'b1;
      r_single.tok_char = 8'h00;
      r_single.kind     = KIND_END;
      mode_nxt          = MODE_BETWEEN;
      held_valid_nxt    = 1'b0;
      held_char_nxt     = 8'h00;
      held_first_nxt    = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_COMMENT: begin
          if (in_ch == CH_NEWLINE) begin
            mode_nxt = MODE_BETWEEN;
          end
        end
        MODE_IDENT:  extend_ok = is_alnum(in_ch);
        MODE_NUMBER: extend_ok = is_digit(in_ch) || (in_ch == CH_DOT);
        MODE_OPER:   extend_ok = is_oper(in_ch);
        default:     classify  = 1'b1;
      endcase

      if (mode_r == MODE_IDENT || mode_r == MODE_NUMBER || mode_r == MODE_OPER) begin
        if (extend_ok) begin
          // token goes on: emit the held character, not marked as last
          has_flush      = 1'b1;
          r_flush.last    = 1'b0;
          r_flush.keyword = KW_NONE;
          held_char_nxt  = in_ch;
          held_first_nxt = 1'b0;
          if (mode_r == MODE_IDENT) begin
            def_ok_nxt = def_ok_r & (p < 3'd3) & (kw_def_char(p) == in_ch);
            ext_ok_nxt = ext_ok_r & (p < 3'd6) & (kw_extern_char(p) == in_ch);
            if (name_len_r != 3'd7) begin
              name_len_nxt = name_len_r + 3'd1;
            end
          end
        end else begin
          // token ends: flush the held character, then classify this byte
          has_flush      = held_valid_r;
          held_valid_nxt = 1'b0;
          classify       = 1'b1;
        end
      end

      if (classify) begin
        mode_nxt = MODE_BETWEEN;
        if (is_space(in_ch)) begin
          mode_nxt = MODE_BETWEEN;
        end else if (in_ch == CH_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else if (is_alpha(in_ch)) begin
          mode_nxt = MODE_IDENT;
          start_id = 1'b1;
        end else if (is_digit(in_ch) || in_ch == CH_DOT) begin
          mode_nxt = MODE_NUMBER;
        end else if (in_ch == CH_OPEN) begin
          has_single    = 1'b1;
          r_single.kind = KIND_OPEN;
        end else if (in_ch == CH_CLOSE) begin
          has_single    = 1'b1;
          r_single.kind = KIND_CLOSE;
        end else if (in_ch == CH_COMMA) begin
          has_single    = 1'b1;
          r_single.kind = KIND_COMMA;
        end else if (in_ch == CH_SEMI) begin
          has_single    = 1'b1;
          r_single.kind = KIND_SEMI;
        end else begin
          mode_nxt = MODE_OPER;
        end

        // start of a multi-character token
        if (mode_nxt == MODE_IDENT || mode_nxt == MODE_NUMBER || mode_nxt == MODE_OPER) begin
          held_char_nxt  = in_ch;
          held_valid_nxt = 1'b1;
          held_first_nxt = 1'b1;
        end
        if (start_id) begin
          name_len_nxt = 3'd1;
          def_ok_nxt   = (in_ch == kw_def_char(3'd0));
          ext_ok_nxt   = (in_ch == kw_extern_char(3'd0));
        end
      end
    end

    // pack results in order
    if (has_flush) begin
      res0 = r_flush;
      res1 = r_single;
    end else begin
      res0 = r_single;
      res1 = r_flush;
    end
    n_res = {1'b0, has_flush} + {1'b0, has_single};
  end

  // queue handshake: take an item only if its results fit
  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid && out_ready;
  assign room_need = {1'b0, cnt_r} - {2'b00, out_acc} + {1'b0, n_res};
  assign in_ready  = (room_need <= 3'(RES_DEPTH));
  assign in_acc    = in_valid && in_ready;
  assign n_push    = in_acc ? n_res : 2'd0;

  assign out_tok_char = res_r[rd_ptr_r].tok_char;
  assign out_kind     = res_r[rd_ptr_r].kind;
  assign out_first    = res_r[rd_ptr_r].first;
  assign out_last     = res_r[rd_ptr_r].last;
  assign out_keyword  = res_r[rd_ptr_r].keyword;

  // scanner state and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BETWEEN;
      held_char_r  <= 8'h00;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
      name_len_r   <= 3'd0;
      def_ok_r     <= 1'b1;
      ext_ok_r     <= 1'b1;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
      cnt_r        <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r       <= mode_nxt;
        held_char_r  <= held_char_nxt;
        held_valid_r <= held_valid_nxt;
        held_first_r <= held_first_nxt;
        name_len_r   <= name_len_nxt;
        def_ok_r     <= def_ok_nxt;
        ext_ok_r     <= ext_ok_nxt;
      end
      wr_ptr_r <= wr_ptr_r ^ n_push[0];
      rd_ptr_r <= rd_ptr_r ^ out_acc;
      cnt_r    <= 2'(room_need - {1'b0, n_res} + {1'b0, n_push});
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      res_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      res_r[~wr_ptr_r] <= res1;
    end
  end

endmodule

`default_nettype wire
